// File: design/mcww_pkg.sv
// ----------------------------------------------------------------------------
// mcww_pkg - shared definitions for the markov chain word walker
// Field widths, command and emit codes, default sizes and the xorshift step.
// ----------------------------------------------------------------------------
package mcww_pkg;

    // default table geometry
    localparam int TABLE_WORDS_DEF = 4096;
    localparam int MAX_SUCC_DEF    = 30;

    // payload field widths
    localparam int MODE_W  = 3;
    localparam int ENTRY_W = 12;
    localparam int SLOT_W  = 5;
    localparam int SEED_W  = 32;
    localparam int KIND_W  = 2;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_START_INDEX = 3'd0;

    // command codes
    localparam logic [MODE_W-1:0] MODE_WR_SUCC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WR_COUNT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LD_SEED  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STEP     = 3'd4;

    // emit codes
    localparam logic [KIND_W-1:0] EMIT_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] EMIT_PERIOD = 2'd1;
    localparam logic [KIND_W-1:0] EMIT_WORD   = 2'd2;
    localparam logic [KIND_W-1:0] EMIT_DEAD   = 2'd3;

    // xorshift32 shift amounts
    localparam int XS_SHL_A = 13;
    localparam int XS_SHR_B = 17;
    localparam int XS_SHL_C = 5;

    // one xorshift32 advance
    function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] x;
        x = s;
        x = x ^ (x << XS_SHL_A);
        x = x ^ (x >> XS_SHR_B);
        x = x ^ (x << XS_SHL_C);
        return x;
    endfunction

endpackage

// File: design/mcww_cmd_if.sv
// ----------------------------------------------------------------------------
// mcww_cmd_if - command channel
// Valid/ready channel carrying one table write, seed load, run start or step.
// ----------------------------------------------------------------------------
interface mcww_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [mcww_pkg::MODE_W-1:0]    mode;
    logic [mcww_pkg::ENTRY_W-1:0]   word;
    logic [mcww_pkg::SLOT_W-1:0]    slot;
    logic [mcww_pkg::ENTRY_W-1:0]   value;
    logic [mcww_pkg::SEED_W-1:0]    seed_value;

    modport source (output valid, mode, word, slot, value, seed_value, input ready);
    modport sink   (input valid, mode, word, slot, value, seed_value, output ready);
endinterface

// File: design/mcww_emit_if.sv
// ----------------------------------------------------------------------------
// mcww_emit_if - emit channel
// Valid/ready channel carrying the outcome of one walk step.
// ----------------------------------------------------------------------------
interface mcww_emit_if;
    logic                           valid;
    logic                           ready;
    logic [mcww_pkg::KIND_W-1:0]    emit_kind;
    logic [mcww_pkg::ENTRY_W-1:0]   word_index;
    logic                           capitalize;

    modport source (output valid, emit_kind, word_index, capitalize, input ready);
    modport sink   (input valid, emit_kind, word_index, capitalize, output ready);
endinterface

// File: design/mcww_ram.sv
// ----------------------------------------------------------------------------
// mcww_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcww_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/markov_chain_word_walker.sv
// ----------------------------------------------------------------------------
// markov_chain_word_walker - markov chain walk over a loaded successor table
// A step on an entry with successors advances a xorshift32 generator and
// picks a squared-biased successor (word, period or none); else a dead end.
// ----------------------------------------------------------------------------
// Usage:
//   cmd   : valid/ready command channel. Modes 0 and 1 load a successor or a
//           successor count, mode 2 loads the seed, mode 3 starts a run at the
//           separator entry, mode 4 takes one step. Only a step gives a transfer
//           on emit; every other mode completes in the cycle it is accepted.
//   emit  : valid/ready result channel, held in an output register.
//   APB   : start_index at byte address 0; the user writes it only while idle (not enforced).
// Step sequence:
//   a step runs through count read, three passes of one shared 32x32
//   multiplier (r*r, then high and low halves times count), a slot select and
//   a table read; cmd.ready returns in the cycle the result becomes valid. A
//   dead end leaves straight from the count read with no multiplier pass.
// Reset and stalls:
//   reset sets the walk to entry 0 at a sentence start with seed 1; the
//   tables are not cleared. A stalled emit holds the finished step in its
//   last state until the previous result has been taken.
// ----------------------------------------------------------------------------
module markov_chain_word_walker #(
    parameter int TABLE_WORDS    = mcww_pkg::TABLE_WORDS_DEF,
    parameter int MAX_SUCCESSORS = mcww_pkg::MAX_SUCC_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mcww_cmd_if.sink                       cmd,
    mcww_emit_if.source                    emit,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mcww_pkg::APB_AW-1:0]    paddr,
    input  logic [mcww_pkg::APB_DW-1:0]    pwdata,
    output logic [mcww_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import mcww_pkg::*;

    localparam int IW    = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
    localparam int SLOTS = TABLE_WORDS * MAX_SUCCESSORS;
    localparam int TAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(MAX_SUCCESSORS + 1);
    localparam int SUMW  = 32 + CW + 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_COUNT = 7'b0000010,
        ST_SQ    = 7'b0000100,
        ST_HI    = 7'b0001000,
        ST_LO    = 7'b0010000,
        ST_ADDR  = 7'b0100000,
        ST_READ  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [ENTRY_W-1:0]   cur_reg, cur_next;
    logic                 sstart_reg, sstart_next;
    logic [SEED_W-1:0]    rng_reg, rng_next;
    logic [SEED_W-1:0]    rnd_reg, rnd_next;
    logic [ENTRY_W-1:0]   start_reg, start_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        sel_reg, sel_next;
    logic [31:0]          sqlo_reg, sqlo_next;
    logic [SUMW-1:0]      hi_reg, hi_next;
    logic [63:0]          prod_reg;
    logic                 ovalid_reg, ovalid_next;
    logic [KIND_W-1:0]    okind_reg, okind_next;
    logic [ENTRY_W-1:0]   oidx_reg, oidx_next;
    logic                 ocap_reg, ocap_next;

    logic                 cmd_xfer;
    logic                 can_emit;
    logic                 cfg_sel;
    logic [31:0]          word32, cur32, val32, wr_addr32, rd_addr32;
    logic [IW-1:0]        word_idx, cur_idx;
    logic                 word_ok, slot_ok, cur_ok;
    logic [CW-1:0]        cnt_sat, cnt_rd, cnt_eff;
    logic [ENTRY_W-1:0]   tbl_rd;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic [SUMW-1:0]      sum;
    logic [CW:0]          sel_raw;

    // handshakes
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign can_emit  = !ovalid_reg || emit.ready;

    assign emit.valid      = ovalid_reg;
    assign emit.emit_kind  = okind_reg;
    assign emit.word_index = oidx_reg;
    assign emit.capitalize = ocap_reg;

    // configuration register
    assign pready     = 1'b1;
    assign cfg_sel    = (paddr[APB_AW-1:2] == REG_START_INDEX[APB_AW-1:2]);
    assign prdata     = cfg_sel ? APB_DW'(start_reg) : '0;
    assign start_next = (psel && penable && pwrite && cfg_sel) ? pwdata[ENTRY_W-1:0]
                                                               : start_reg;

    // write address decode and count saturation
    assign word32    = 32'(cmd.word);
    assign word_idx  = word32[IW-1:0];
    assign word_ok   = word32 < 32'(TABLE_WORDS);
    assign slot_ok   = 32'(cmd.slot) < 32'(MAX_SUCCESSORS);
    assign wr_addr32 = 32'(word_idx) * 32'(MAX_SUCCESSORS) + 32'(cmd.slot);
    assign val32     = 32'(cmd.value);
    assign cnt_sat   = (val32 > 32'(MAX_SUCCESSORS)) ? CW'(MAX_SUCCESSORS) : val32[CW-1:0];

    // current entry decode and table read address
    assign cur32     = 32'(cur_reg);
    assign cur_idx   = cur32[IW-1:0];
    assign cur_ok    = cur32 < 32'(TABLE_WORDS);
    assign cnt_eff   = cur_ok ? cnt_rd : '0;
    assign rd_addr32 = 32'(cur_idx) * 32'(MAX_SUCCESSORS) + 32'(sel_reg);

    // successor counts
    mcww_ram #(
        .WIDTH (CW),
        .DEPTH (TABLE_WORDS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cmd_xfer && (cmd.mode == MODE_WR_COUNT) && word_ok),
        .waddr (word_idx),
        .wdata (cnt_sat),
        .re    (cmd_xfer && (cmd.mode == MODE_STEP)),
        .raddr (cur_idx),
        .rdata (cnt_rd)
    );

    // successor lists
    mcww_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_succ_ram (
        .clk   (clk),
        .we    (cmd_xfer && (cmd.mode == MODE_WR_SUCC) && word_ok && slot_ok),
        .waddr (wr_addr32[TAW-1:0]),
        .wdata (cmd.value),
        .re    (state_reg == ST_ADDR),
        .raddr (rd_addr32[TAW-1:0]),
        .rdata (tbl_rd)
    );

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_COUNT:
            begin
                mul_a = rnd_reg;
                mul_b = rnd_reg;
            end
            ST_SQ:
            begin
                mul_a = prod_reg[63:32];
                mul_b = 32'(cnt_reg);
            end
            ST_HI:
            begin
                mul_a = sqlo_reg;
                mul_b = 32'(cnt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // slot select from the scaled square
    assign sum     = hi_reg + SUMW'(prod_reg[63:32]);
    assign sel_raw = sum[SUMW-1:32];

    // step sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        sstart_next = sstart_reg;
        rng_next    = rng_reg;
        rnd_next    = rnd_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        sqlo_next   = sqlo_reg;
        hi_next     = hi_reg;
        ovalid_next = ovalid_reg && !emit.ready;
        okind_next  = okind_reg;
        oidx_next   = oidx_reg;
        ocap_next   = ocap_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    unique case (cmd.mode)
                        MODE_LD_SEED:
                        begin
                            rng_next = (cmd.seed_value != '0) ? cmd.seed_value
                                                              : SEED_W'(1);
                        end
                        MODE_START:
                        begin
                            cur_next    = start_reg;
                            sstart_next = 1'b1;
                        end
                        MODE_STEP:
                        begin
                            rnd_next   = xorshift32(rng_reg);
                            state_next = ST_COUNT;
                        end
                        default:
                        begin
                            // table writes go straight to the rams; unused modes do nothing
                        end
                    endcase
                end
            end
            ST_COUNT:
            begin
                cnt_next = cnt_eff;
                if (cnt_eff == '0)
                begin
                    // dead end, generator untouched
                    if (can_emit)
                    begin
                        ovalid_next = 1'b1;
                        okind_next  = EMIT_DEAD;
                        oidx_next   = cur_reg;
                        ocap_next   = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    rng_next   = rnd_reg;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sqlo_next  = prod_reg[31:0];
                state_next = ST_HI;
            end
            ST_HI:
            begin
                hi_next    = prod_reg[SUMW-1:0];
                state_next = ST_LO;
            end
            ST_LO:
            begin
                if ((CW + 1)'(cnt_reg) <= sel_raw)
                begin
                    sel_next = cnt_reg - CW'(1);
                end
                else
                begin
                    sel_next = sel_raw[CW-1:0];
                end
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (can_emit)
                begin
                    cur_next    = tbl_rd;
                    ovalid_next = 1'b1;
                    oidx_next   = tbl_rd;
                    if (tbl_rd == start_reg)
                    begin
                        // separator: period only once per sentence
                        okind_next  = sstart_reg ? EMIT_NONE : EMIT_PERIOD;
                        ocap_next   = 1'b0;
                        sstart_next = 1'b1;
                    end
                    else
                    begin
                        okind_next  = EMIT_WORD;
                        ocap_next   = sstart_reg;
                        sstart_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            sstart_reg <= 1'b1;
            rng_reg    <= SEED_W'(1);
            start_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            sstart_reg <= sstart_next;
            rng_reg    <= rng_next;
            start_reg  <= start_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rnd_reg   <= rnd_next;
        cnt_reg   <= cnt_next;
        sel_reg   <= sel_next;
        sqlo_reg  <= sqlo_next;
        hi_reg    <= hi_next;
        prod_reg  <= mul_p;
        okind_reg <= okind_next;
        oidx_reg  <= oidx_next;
        ocap_reg  <= ocap_next;
    end

endmodule

// File: design/mcww_chk.sv
// ----------------------------------------------------------------------------
// mcww_chk - port-level checks for the word walker
// Watches the command and emit channels and flags handshake or sequencing slips.
// ----------------------------------------------------------------------------
module mcww_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_ready,
    input  logic [mcww_pkg::MODE_W-1:0]    cmd_mode,
    input  logic                           emit_valid,
    input  logic                           emit_ready,
    input  logic [mcww_pkg::KIND_W-1:0]    emit_kind,
    input  logic [mcww_pkg::ENTRY_W-1:0]   word_index,
    input  logic                           capitalize
);

    import mcww_pkg::*;

    // a stalled result stays offered
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid && !emit_ready |=> emit_valid)
        else $error("emit valid dropped while stalled");

    // a stalled result keeps its payload
    a_emit_stable: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid && !emit_ready |=>
            $stable(emit_kind) && $stable(word_index) && $stable(capitalize))
        else $error("emit payload changed while stalled");

    // an accepted step closes the command channel
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_mode == MODE_STEP) |=> !cmd_ready)
        else $error("command accepted during a step");

    // table writes, seed loads and run starts give no transfer on emit
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_mode != MODE_STEP) && !emit_valid
            |=> !emit_valid)
        else $error("result without a step");

endmodule

bind markov_chain_word_walker mcww_chk u_mcww_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_mode   (cmd.mode),
    .emit_valid (emit.valid),
    .emit_ready (emit.ready),
    .emit_kind  (emit.emit_kind),
    .word_index (emit.word_index),
    .capitalize (emit.capitalize)
);

// File: dv/tb_markov_chain_word_walker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_markov_chain_word_walker - self-checking bench for the word walker
// Builds a closed vocabulary of table entries so that every walk step reads
// only written entries. Steps, seed loads, run starts and table rewrites are
// driven with random gaps on both channels. The generator, slot pick and
// sentence tracking are predicted in the bench, and each emit transfer is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_markov_chain_word_walker;
    import mcww_pkg::*;

    localparam int LAST_ENTRY  = TABLE_WORDS_DEF - 1;
    localparam int VALUE_MAX   = (1 << ENTRY_W) - 1;
    localparam int SLOT_MAX    = (1 << SLOT_W) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 12;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ENTRY_W-1:0] word;
        logic [SLOT_W-1:0]  slot;
        logic [ENTRY_W-1:0] value;
        logic [SEED_W-1:0]  seed;
    } walk_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ENTRY_W-1:0] index;
        logic               capital;
    } walk_emit_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    mcww_cmd_if  cmd_ch ();
    mcww_emit_if emit_ch ();

    markov_chain_word_walker dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .emit    (emit_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // channel pacing
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          hold_req;
    bit          hold_taken;
    int unsigned hold_left;

    walk_cmd_t  cmd_pending [$];
    walk_emit_t step_expect [$];
    walk_cmd_t  drv_item;
    walk_cmd_t  seen_cmd;
    walk_emit_t want;
    int         fail_count;

    // predicted block state
    logic [ENTRY_W-1:0] succ_mem [TABLE_WORDS_DEF*MAX_SUCC_DEF];
    logic [SLOT_W-1:0]  count_mem [TABLE_WORDS_DEF];
    logic [ENTRY_W-1:0] walk_pos;
    logic [ENTRY_W-1:0] sep_index;
    logic               sentence_open;
    logic [SEED_W-1:0]  rng;

    // vocabulary bookkeeping for the stimulus
    int vocab [$];
    bit in_vocab [TABLE_WORDS_DEF];
    int filled [TABLE_WORDS_DEF];
    int queued_items;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // one walk step on the predicted state
    task automatic take_step();
        logic [SLOT_W-1:0]  n;
        logic [SLOT_W-1:0]  pick;
        logic [63:0]        sq;
        logic [68:0]        scaled;
        logic [ENTRY_W-1:0] nxt;
        walk_emit_t         r;
        n = count_mem[walk_pos];
        if (n == 0)
        begin
            r.kind    = EMIT_DEAD;
            r.index   = walk_pos;
            r.capital = 1'b0;
        end
        else
        begin
            rng    = rng ^ (rng << XS_SHL_A);
            rng    = rng ^ (rng >> XS_SHR_B);
            rng    = rng ^ (rng << XS_SHL_C);
            sq     = {32'd0, rng} * {32'd0, rng};
            scaled = {5'd0, sq} * {64'd0, n};
            pick   = scaled[68:64];
            if (pick >= n)
                pick = n - 1'b1;
            nxt      = succ_mem[int'(walk_pos) * MAX_SUCC_DEF + int'(pick)];
            walk_pos = nxt;
            r.index  = nxt;
            if (nxt == sep_index)
            begin
                r.capital     = 1'b0;
                r.kind        = sentence_open ? EMIT_NONE : EMIT_PERIOD;
                sentence_open = 1'b1;
            end
            else
            begin
                r.kind        = EMIT_WORD;
                r.capital     = sentence_open;
                sentence_open = 1'b0;
            end
        end
        step_expect.push_back(r);
    endtask

    task automatic apply_command(input walk_cmd_t c);
        case (c.mode)
            MODE_WR_SUCC:
                if (int'(c.slot) < MAX_SUCC_DEF)
                    succ_mem[int'(c.word) * MAX_SUCC_DEF + int'(c.slot)] = c.value;
            MODE_WR_COUNT:
                count_mem[c.word] = (c.value > MAX_SUCC_DEF) ? SLOT_W'(MAX_SUCC_DEF)
                                                              : c.value[SLOT_W-1:0];
            MODE_LD_SEED:
                rng = (c.seed == '0) ? SEED_W'(1) : c.seed;
            MODE_START:
            begin
                walk_pos      = sep_index;
                sentence_open = 1'b1;
            end
            MODE_STEP:
                take_step();
            default:
                ;
        endcase
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.mode       <= '0;
            cmd_ch.word       <= '0;
            cmd_ch.slot       <= '0;
            cmd_ch.value      <= '0;
            cmd_ch.seed_value <= '0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                drv_item = cmd_pending.pop_front();
                cmd_ch.valid      <= 1'b1;
                cmd_ch.mode       <= drv_item.mode;
                cmd_ch.word       <= drv_item.word;
                cmd_ch.slot       <= drv_item.slot;
                cmd_ch.value      <= drv_item.value;
                cmd_ch.seed_value <= drv_item.seed;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // emit ready, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_ch.ready <= 1'b0;
            hold_left     <= 0;
            hold_taken    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            emit_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            emit_ch.ready <= 1'b0;
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
        end
        else
            emit_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // monitor: predict on each command transfer, check each emit transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            walk_pos      = '0;
            sentence_open = 1'b1;
            rng           = SEED_W'(1);
            sep_index     = '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen_cmd.mode  = cmd_ch.mode;
                seen_cmd.word  = cmd_ch.word;
                seen_cmd.slot  = cmd_ch.slot;
                seen_cmd.value = cmd_ch.value;
                seen_cmd.seed  = cmd_ch.seed_value;
                apply_command(seen_cmd);
            end
            if (emit_ch.valid && emit_ch.ready)
            begin
                if (step_expect.size() == 0)
                    report_mismatch($sformatf("unexpected transfer kind %0d index %0d",
                                              emit_ch.emit_kind, emit_ch.word_index));
                else
                begin
                    want = step_expect.pop_front();
                    if (emit_ch.emit_kind !== want.kind)
                        report_mismatch($sformatf("emit_kind %0d, predicted %0d",
                                                  emit_ch.emit_kind, want.kind));
                    if (emit_ch.word_index !== want.index)
                        report_mismatch($sformatf("word_index %0d, predicted %0d",
                                                  emit_ch.word_index, want.index));
                    if (emit_ch.capitalize !== want.capital)
                        report_mismatch($sformatf("capitalize %0b, predicted %0b",
                                                  emit_ch.capitalize, want.capital));
                end
            end
        end
    end

    // stimulus helpers; fields a mode does not use are filled at random
    task automatic queue_cmd(input logic [MODE_W-1:0] m, input int w, input int s,
                             input int v, input logic [SEED_W-1:0] sd, input bit counted);
        walk_cmd_t c;
        c.mode  = m;
        c.word  = (m == MODE_WR_SUCC || m == MODE_WR_COUNT) ? ENTRY_W'(w) : ENTRY_W'($urandom);
        c.slot  = (m == MODE_WR_SUCC) ? SLOT_W'(s) : SLOT_W'($urandom);
        c.value = (m == MODE_WR_SUCC || m == MODE_WR_COUNT) ? ENTRY_W'(v) : ENTRY_W'($urandom);
        c.seed  = (m == MODE_LD_SEED) ? sd : SEED_W'($urandom);
        cmd_pending.push_back(c);
        if (counted)
            queued_items++;
    endtask

    function automatic int any_vocab();
        return vocab[$urandom_range(vocab.size() - 1)];
    endfunction

    // fill an entry's successors from the vocabulary, then its count
    task automatic grow_vocab(input int w, input int n, input bit saturate);
        for (int i = 0; i < n; i++)
            queue_cmd(MODE_WR_SUCC, w, i, (vocab.size() != 0) ? any_vocab() : w, '0, 1'b1);
        queue_cmd(MODE_WR_COUNT, w, 0,
                  saturate ? $urandom_range(VALUE_MAX, MAX_SUCC_DEF + 1) : n, '0, 1'b1);
        if (!in_vocab[w])
        begin
            in_vocab[w] = 1'b1;
            vocab.push_back(w);
            filled[w] = n;
        end
        else if (n > filled[w])
            filled[w] = n;
    endtask

    task automatic rewire(input int w, input int target);
        int s;
        s = $urandom_range((filled[w] < MAX_SUCC_DEF) ? filled[w] : MAX_SUCC_DEF - 1, 0);
        queue_cmd(MODE_WR_SUCC, w, s, target, '0, 1'b1);
        if (s == filled[w])
            filled[w]++;
    endtask

    task automatic recount(input int w);
        int v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = (filled[w] == MAX_SUCC_DEF) ? $urandom_range(VALUE_MAX, MAX_SUCC_DEF)
                                               : filled[w];
            default: v = $urandom_range(filled[w], 1);
        endcase
        queue_cmd(MODE_WR_COUNT, w, 0, v, '0, 1'b1);
    endtask

    // unused modes, dropped slots, writes to entries the walk never reaches
    task automatic queue_noise();
        int w;
        case ($urandom_range(2))
            0: queue_cmd(MODE_W'($urandom_range(7, int'(MODE_STEP) + 1)), 0, 0, 0, '0, 1'b0);
            1: queue_cmd(MODE_WR_SUCC, $urandom_range(LAST_ENTRY),
                         $urandom_range(SLOT_MAX, MAX_SUCC_DEF), $urandom_range(VALUE_MAX),
                         '0, 1'b0);
            default:
            begin
                w = $urandom_range(LAST_ENTRY);
                if (!in_vocab[w])
                    queue_cmd($urandom_range(1) ? MODE_WR_COUNT : MODE_WR_SUCC, w,
                              $urandom_range(MAX_SUCC_DEF - 1), $urandom_range(VALUE_MAX),
                              '0, 1'b1);
            end
        endcase
    endtask

    task automatic directed_walk();
        // dead end on an entry with no successors
        queue_cmd(MODE_WR_COUNT, 0, 0, 0, '0, 1'b1);
        queue_cmd(MODE_STEP, 0, 0, 0, '0, 1'b1);
        // zero seed loads as one
        queue_cmd(MODE_LD_SEED, 0, 0, 0, '0, 1'b1);
        // separator at the top entry: back to itself, or on to entry 0
        queue_cmd(MODE_WR_SUCC, LAST_ENTRY, 0, LAST_ENTRY, '0, 1'b1);
        queue_cmd(MODE_WR_SUCC, LAST_ENTRY, 1, 0, '0, 1'b1);
        // slots past the end of the list are dropped
        queue_cmd(MODE_WR_SUCC, LAST_ENTRY, MAX_SUCC_DEF, 12'h5a5, '0, 1'b0);
        queue_cmd(MODE_WR_SUCC, LAST_ENTRY, SLOT_MAX, 12'ha5a, '0, 1'b0);
        queue_cmd(MODE_WR_COUNT, LAST_ENTRY, 0, 2, '0, 1'b1);
        // entry 0 leads back to the separator, giving a period
        queue_cmd(MODE_WR_SUCC, 0, 0, LAST_ENTRY, '0, 1'b1);
        queue_cmd(MODE_WR_COUNT, 0, 0, 1, '0, 1'b1);
        queue_cmd(MODE_START, 0, 0, 0, '0, 1'b1);
        repeat (6)
            queue_cmd(MODE_STEP, 0, 0, 0, '0, 1'b1);
        for (int m = int'(MODE_STEP) + 1; m <= 7; m++)
            queue_cmd(MODE_W'(m), 0, 0, 0, '0, 1'b0);
        queue_cmd(MODE_LD_SEED, 0, 0, 0, 32'hffff_ffff, 1'b1);
        repeat (4)
            queue_cmd(MODE_STEP, 0, 0, 0, '0, 1'b1);
        in_vocab[0]          = 1'b1;
        in_vocab[LAST_ENTRY] = 1'b1;
        vocab.push_back(0);
        vocab.push_back(LAST_ENTRY);
        filled[0]          = 1;
        filled[LAST_ENTRY] = 2;
    endtask

    task automatic random_phase(input int n_items);
        int target;
        int w;
        int pct;
        target = queued_items + n_items;
        while (queued_items < target)
        begin
            pct = $urandom_range(99);
            if (pct < 66)
                queue_cmd(MODE_STEP, 0, 0, 0, '0, 1'b1);
            else if (pct < 72)
                queue_cmd(MODE_START, 0, 0, 0, '0, 1'b1);
            else if (pct < 76)
                queue_cmd(MODE_LD_SEED, 0, 0, 0,
                          ($urandom_range(15) == 0) ? SEED_W'(0) : SEED_W'($urandom), 1'b1);
            else if (pct < 85)
                rewire(any_vocab(), any_vocab());
            else if (pct < 91)
                recount(any_vocab());
            else if (pct < 94)
            begin
                w = $urandom_range(LAST_ENTRY);
                if (!in_vocab[w])
                begin
                    grow_vocab(w, $urandom_range(6, 1), 1'b0);
                    rewire(any_vocab(), w);
                end
            end
            else
                queue_noise();
        end
    endtask

    // wait until nothing is in flight, then let the block go quiet
    task automatic settle();
        while (cmd_pending.size() != 0 || cmd_ch.valid || step_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_START_INDEX)
            sep_index = data[ENTRY_W-1:0];
    endtask

    task automatic new_run(input int sep);
        apb_write(REG_START_INDEX, APB_DW'(sep));
        queue_cmd(MODE_START, 0, 0, 0, '0, 1'b1);
    endtask

    // main sequence
    initial
    begin
        int w;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.mode       = '0;
        cmd_ch.word       = '0;
        cmd_ch.slot       = '0;
        cmd_ch.value      = '0;
        cmd_ch.seed_value = '0;
        emit_ch.ready     = 1'b0;
        hold_req          = 1'b0;
        fail_count        = 0;
        queued_items      = 0;
        src_idle_pct      = 11;
        snk_idle_pct      = 61;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // separator at the top entry, directed items, then a saturated entry
        apb_write(REG_START_INDEX, APB_DW'(LAST_ENTRY));
        directed_walk();
        do
            w = $urandom_range(LAST_ENTRY);
        while (in_vocab[w]);
        grow_vocab(w, MAX_SUCC_DEF, 1'b1);
        rewire(LAST_ENTRY, w);
        random_phase(240);
        settle();

        // separator at entry 0, receiver mostly ready
        src_idle_pct = 61;
        snk_idle_pct = 11;
        new_run(0);
        random_phase(240);
        settle();

        // separator anywhere in the vocabulary, no idling, one long hold-off
        src_idle_pct = 0;
        snk_idle_pct = 0;
        new_run(any_vocab());
        random_phase(240);
        hold_req = 1'b1;
        settle();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** markov_chain_word_walker: PASSED **");
        else
            $display("** markov_chain_word_walker: FAILED **");
        $finish;
    end

    // overall time limit
    initial
    begin
        #2_000_000;
        $display("** markov_chain_word_walker: FAILED **");
        $finish;
    end

endmodule

// File: files.f
design/mcww_pkg.sv
design/mcww_cmd_if.sv
design/mcww_emit_if.sv
design/mcww_ram.sv
design/markov_chain_word_walker.sv
design/mcww_chk.sv
dv/tb_markov_chain_word_walker.sv
